/* src/jtl_pkg.sv */
// Shared types and constants for the JSON token lexer.
package jtl_pkg;

	// Largest document size supported, in bytes
	localparam int MAX_DOC_BYTES = 65536;
	localparam int POS_LIMIT_INT = (MAX_DOC_BYTES < 65536) ? MAX_DOC_BYTES : 65536;
	localparam logic [16:0] POS_LIMIT = 17'(POS_LIMIT_INT);
	localparam logic [15:0] POS_LAST  = 16'(POS_LIMIT_INT - 1);
	localparam logic [15:0] POS_SAT   = 16'hFFFF;

	// Token kinds
	localparam logic [3:0] K_LBRACE   = 4'd0;
	localparam logic [3:0] K_RBRACE   = 4'd1;
	localparam logic [3:0] K_LBRACKET = 4'd2;
	localparam logic [3:0] K_RBRACKET = 4'd3;
	localparam logic [3:0] K_COMMA    = 4'd4;
	localparam logic [3:0] K_COLON    = 4'd5;
	localparam logic [3:0] K_STRING   = 4'd6;
	localparam logic [3:0] K_NUMBER   = 4'd7;
	localparam logic [3:0] K_END      = 4'd8;
	localparam logic [3:0] K_ERROR    = 4'd9;

	// Error codes
	localparam logic [2:0] E_NONE       = 3'd0;
	localparam logic [2:0] E_BAD_ESCAPE = 3'd1;
	localparam logic [2:0] E_END_STRING = 3'd2;
	localparam logic [2:0] E_END_NUMBER = 3'd3;
	localparam logic [2:0] E_BAD_CHAR   = 3'd4;
	localparam logic [2:0] E_TOO_LONG   = 3'd5;

	// Lexer modes
	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_STR  = 3'd1;
	localparam logic [2:0] M_ESC  = 3'd2;
	localparam logic [2:0] M_NUM  = 3'd3;
	localparam logic [2:0] M_SKIP = 3'd4;

	// Character constants
	localparam logic [7:0] C_LBRACE    = 8'h7B;
	localparam logic [7:0] C_RBRACE    = 8'h7D;
	localparam logic [7:0] C_LBRACKET  = 8'h5B;
	localparam logic [7:0] C_RBRACKET  = 8'h5D;
	localparam logic [7:0] C_COMMA     = 8'h2C;
	localparam logic [7:0] C_COLON     = 8'h3A;
	localparam logic [7:0] C_QUOTE     = 8'h22;
	localparam logic [7:0] C_BACKSLASH = 8'h5C;
	localparam logic [7:0] C_DOT       = 8'h2E;
	localparam logic [7:0] C_LOWER_E   = 8'h65;
	localparam logic [7:0] C_MINUS     = 8'h2D;
	localparam logic [7:0] C_SPACE     = 8'h20;
	localparam logic [7:0] C_TAB       = 8'h09;
	localparam logic [7:0] C_LF        = 8'h0A;
	localparam logic [7:0] C_CR        = 8'h0D;
	localparam logic [7:0] C_FF        = 8'h0C;
	localparam logic [7:0] C_ZERO      = 8'h30;
	localparam logic [7:0] C_NINE      = 8'h39;
	localparam logic [7:0] C_LOWER_B   = 8'h62;
	localparam logic [7:0] C_LOWER_F   = 8'h66;
	localparam logic [7:0] C_LOWER_N   = 8'h6E;
	localparam logic [7:0] C_LOWER_R   = 8'h72;
	localparam logic [7:0] C_LOWER_T   = 8'h74;

	localparam int MAX_RESULTS = 3;

	// One emitted token
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [16:0] length;
		logic [2:0]  err;
	} jtl_result_t;

	// All tokens caused by one input byte
	typedef struct packed {
		jtl_result_t [MAX_RESULTS-1:0] res;
		logic [1:0]                    count;
	} jtl_bundle_t;

endpackage

/* src/jtl_lex_core.sv */
// Input register, lexer state and per-byte token decode.
module jtl_lex_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 doc_last,
	input  logic                 buf_free,
	output logic                 bundle_load,
	output jtl_pkg::jtl_bundle_t bundle
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [2:0]  mode_q;
	logic [16:0] pos_q;
	logic [15:0] tok_start_q;

	logic [2:0]  mode_d;
	logic [16:0] pos_d;
	logic [15:0] tok_start_d;
	logic        advance;

	logic        is_punct;
	logic [3:0]  punct_kind;
	logic        is_ws;
	logic        is_digit;
	logic        is_num_start;
	logic        is_num_cont;
	logic        is_esc;

	jtl_pkg::jtl_bundle_t bnd;

	// Character classes of the registered byte
	always_comb begin
		is_punct   = 1'b1;
		punct_kind = jtl_pkg::K_LBRACE;
		case (byte_s1)
			jtl_pkg::C_LBRACE:   punct_kind = jtl_pkg::K_LBRACE;
			jtl_pkg::C_RBRACE:   punct_kind = jtl_pkg::K_RBRACE;
			jtl_pkg::C_LBRACKET: punct_kind = jtl_pkg::K_LBRACKET;
			jtl_pkg::C_RBRACKET: punct_kind = jtl_pkg::K_RBRACKET;
			jtl_pkg::C_COMMA:    punct_kind = jtl_pkg::K_COMMA;
			jtl_pkg::C_COLON:    punct_kind = jtl_pkg::K_COLON;
			default:             is_punct = 1'b0;
		endcase
	end

	assign is_ws = (byte_s1 == jtl_pkg::C_SPACE) || (byte_s1 == jtl_pkg::C_TAB)
		|| (byte_s1 == jtl_pkg::C_LF) || (byte_s1 == jtl_pkg::C_CR)
		|| (byte_s1 == jtl_pkg::C_FF);
	assign is_digit     = (byte_s1 >= jtl_pkg::C_ZERO) && (byte_s1 <= jtl_pkg::C_NINE);
	assign is_num_start = is_digit || (byte_s1 == jtl_pkg::C_MINUS);
	assign is_num_cont  = is_digit || (byte_s1 == jtl_pkg::C_DOT)
		|| (byte_s1 == jtl_pkg::C_LOWER_E);
	assign is_esc = (byte_s1 == jtl_pkg::C_LOWER_B) || (byte_s1 == jtl_pkg::C_LOWER_F)
		|| (byte_s1 == jtl_pkg::C_LOWER_N) || (byte_s1 == jtl_pkg::C_LOWER_R)
		|| (byte_s1 == jtl_pkg::C_LOWER_T) || (byte_s1 == jtl_pkg::C_QUOTE)
		|| (byte_s1 == jtl_pkg::C_BACKSLASH);

	// Token decode and next state for one byte
	always_comb begin
		logic        err;
		logic        do_idle;
		logic [1:0]  n;
		logic [16:0] pos_inc;
		logic [15:0] end_pos;

		bnd         = '0;
		n           = 2'd0;
		err         = 1'b0;
		do_idle     = 1'b0;
		mode_d      = mode_q;
		pos_d       = pos_q;
		tok_start_d = tok_start_q;
		pos_inc     = pos_q + 17'd1;
		end_pos     = pos_inc[16] ? jtl_pkg::POS_SAT : pos_inc[15:0];

		if (mode_q == jtl_pkg::M_SKIP) begin
			if (last_s1) begin
				mode_d      = jtl_pkg::M_IDLE;
				pos_d       = '0;
				tok_start_d = '0;
			end
		end else begin
			if (pos_q >= jtl_pkg::POS_LIMIT) begin
				bnd.res[n] = '{jtl_pkg::K_ERROR, jtl_pkg::POS_LAST, 17'd0,
					jtl_pkg::E_TOO_LONG};
				n   = n + 2'd1;
				err = 1'b1;
			end else begin
				case (mode_q)
					jtl_pkg::M_STR: begin
						if (byte_s1 == jtl_pkg::C_QUOTE) begin
							bnd.res[n] = '{jtl_pkg::K_STRING, tok_start_q,
								pos_inc - {1'b0, tok_start_q}, jtl_pkg::E_NONE};
							n      = n + 2'd1;
							mode_d = jtl_pkg::M_IDLE;
						end else if (byte_s1 == jtl_pkg::C_BACKSLASH) begin
							mode_d = jtl_pkg::M_ESC;
						end
					end
					jtl_pkg::M_ESC: begin
						if (is_esc) begin
							mode_d = jtl_pkg::M_STR;
						end else begin
							bnd.res[n] = '{jtl_pkg::K_ERROR, pos_q[15:0], 17'd0,
								jtl_pkg::E_BAD_ESCAPE};
							n   = n + 2'd1;
							err = 1'b1;
						end
					end
					jtl_pkg::M_NUM: begin
						if (!is_num_cont) begin
							bnd.res[n] = '{jtl_pkg::K_NUMBER, tok_start_q,
								pos_q - {1'b0, tok_start_q}, jtl_pkg::E_NONE};
							n       = n + 2'd1;
							mode_d  = jtl_pkg::M_IDLE;
							do_idle = 1'b1;
						end
					end
					default: begin
						mode_d  = jtl_pkg::M_IDLE;
						do_idle = 1'b1;
					end
				endcase

				// Byte seen outside any open token
				if (do_idle) begin
					if (is_punct) begin
						bnd.res[n] = '{punct_kind, pos_q[15:0], 17'd1, jtl_pkg::E_NONE};
						n = n + 2'd1;
					end else if (byte_s1 == jtl_pkg::C_QUOTE) begin
						mode_d      = jtl_pkg::M_STR;
						tok_start_d = pos_q[15:0];
					end else if (is_ws) begin
						mode_d = jtl_pkg::M_IDLE;
					end else if (is_num_start) begin
						mode_d      = jtl_pkg::M_NUM;
						tok_start_d = pos_q[15:0];
					end else begin
						bnd.res[n] = '{jtl_pkg::K_ERROR, pos_q[15:0], 17'd0,
							jtl_pkg::E_BAD_CHAR};
						n   = n + 2'd1;
						err = 1'b1;
					end
				end
			end

			// Error handling and end of document
			if (err) begin
				if (last_s1) begin
					mode_d      = jtl_pkg::M_IDLE;
					pos_d       = '0;
					tok_start_d = '0;
				end else begin
					mode_d = jtl_pkg::M_SKIP;
				end
			end else begin
				pos_d = pos_inc;
				if (last_s1) begin
					if ((mode_d == jtl_pkg::M_STR) || (mode_d == jtl_pkg::M_ESC)) begin
						bnd.res[n] = '{jtl_pkg::K_ERROR, end_pos, 17'd0,
							jtl_pkg::E_END_STRING};
					end else if (mode_d == jtl_pkg::M_NUM) begin
						bnd.res[n] = '{jtl_pkg::K_ERROR, end_pos, 17'd0,
							jtl_pkg::E_END_NUMBER};
					end else begin
						bnd.res[n] = '{jtl_pkg::K_END, end_pos, 17'd0, jtl_pkg::E_NONE};
					end
					n           = n + 2'd1;
					mode_d      = jtl_pkg::M_IDLE;
					pos_d       = '0;
					tok_start_d = '0;
				end
			end
		end
		bnd.count = n;
	end

	// A byte with no tokens never waits for the result buffer
	assign advance     = valid_s1 && ((bnd.count == 2'd0) || buf_free);
	assign bundle_load = advance && (bnd.count != 2'd0);
	assign bundle      = bnd;
	assign in_ready    = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= doc_last;
		end
	end

	// Lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= jtl_pkg::M_IDLE;
			pos_q       <= '0;
			tok_start_q <= '0;
		end else if (advance) begin
			mode_q      <= mode_d;
			pos_q       <= pos_d;
			tok_start_q <= tok_start_d;
		end
	end

endmodule

/* src/jtl_out_buf.sv */
// Result register holding one byte's tokens and sending them one per cycle while out_ready is high.
module jtl_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  jtl_pkg::jtl_bundle_t bundle,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output jtl_pkg::jtl_result_t result,
	output logic                 last
);

	jtl_pkg::jtl_result_t [jtl_pkg::MAX_RESULTS-1:0] res_q;
	logic [1:0] count_q;
	logic [1:0] idx_q;
	logic [1:0] idx_inc;

	assign idx_inc   = idx_q + 2'd1;
	assign out_valid = (idx_q != count_q);
	assign last      = (idx_inc == count_q);
	assign result    = res_q[idx_q];
	assign free      = !out_valid || (out_ready && last);

	// Transaction counter within the held bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else if (load) begin
			count_q <= bundle.count;
			idx_q   <= '0;
		end else if (out_valid && out_ready) begin
			idx_q <= idx_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bundle.res;
		end
	end

endmodule

/* src/json_token_lexer.sv */
// JSON token lexer: input register, lexer decode and result buffer.
// A token passes from the input register through the lexer decode into the result buffer.
// Throughput: one byte per cycle while out_ready is high; after a byte giving two or three
// tokens, the next byte that gives tokens waits while the result buffer drains.
// Reset (arst_n low, asynchronous): idle mode, offset 0, input and result stages empty.
module json_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        doc_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_kind,
	output logic [15:0] token_start,
	output logic [16:0] token_length,
	output logic [2:0]  error_code,
	output logic        run_last
);

	jtl_pkg::jtl_bundle_t bundle;
	jtl_pkg::jtl_result_t result;
	logic                 bundle_load;
	logic                 buf_free;

	jtl_lex_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.doc_last    (doc_last),
		.buf_free    (buf_free),
		.bundle_load (bundle_load),
		.bundle      (bundle)
	);

	jtl_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (bundle_load),
		.bundle    (bundle),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.last      (run_last)
	);

	assign token_kind   = result.kind;
	assign token_start  = result.start;
	assign token_length = result.length;
	assign error_code   = result.err;

endmodule
